>>> sv/lzwd_pkg.sv
// Shared constants, the dictionary entry type and helper functions for the
// LZW code stream decoder. No dependencies.
package lzwd_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int MAX_RUN      = 64;
  localparam int SYMBOL_BITS  = 21;

  localparam int CODE_W     = 21;
  localparam int REF_W      = 22;
  localparam int FIRST_FREE = 256;

  localparam int IDX_W   = $clog2(DICT_ENTRIES);
  localparam int NFC_W   = ($clog2(DICT_ENTRIES) + 1 > 9) ? $clog2(DICT_ENTRIES) + 1 : 9;
  localparam int RING_AW = $clog2(MAX_RUN);
  localparam int CNT_W   = $clog2(MAX_RUN + 2);

  localparam logic [CODE_W-1:0] SYM_MASK =
    (SYMBOL_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((64'd1 << SYMBOL_BITS) - 64'd1);

  // bit 21 of a string reference: literal symbol held in bits 20..0
  localparam int LIT_BIT = 21;

  typedef struct packed {
    logic [REF_W-1:0]  prefix;
    logic [CODE_W-1:0] tail;
    logic [CODE_W-1:0] head;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [CODE_W-1:0] sym_mask(input logic [CODE_W-1:0] s);
    return s & SYM_MASK;
  endfunction

  function automatic logic is_literal(input logic [REF_W-1:0] r);
    logic [CODE_W-1:0] v;
    v = r[CODE_W-1:0];
    return r[LIT_BIT] || (v < CODE_W'(FIRST_FREE)) || (32'(v) >= DICT_ENTRIES);
  endfunction

endpackage

>>> sv/lzwd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lzw_code_stream_decoder_top.sv
// LZW code stream decoder, top level: sequencer, dictionary and symbol ring.
// Depends on lzwd_pkg and lzwd_ram.
//
// Channel | Dir | Signals                        | Contents
// s       | in  | s_tvalid s_tready s_tdata s_tuser | one LZW code per transaction
// m       | out | m_tvalid m_tready m_tdata m_tlast m_tuser | one decoded symbol
//
// Sequence, with m_tready held high: a code is taken, then a walk step, then the
//   output is set up, then the symbols it emits (at most MAX_RUN) are sent in turn.
//   When the walked string (the code's own, or the previous one for an undefined
//   code) has L > 1 symbols, the chain walk adds a dictionary read per entry
//   and then a walk step that pushes the root.
// Reset: rst clears the sequencer, the ring pointers, m_tvalid and the dictionary
//   fill counter; the dictionary and ring contents are never cleared, only read once written.
// Stalls: s_tready is high only while idle; the last symbol may still sit in
//   the output register while the next code is taken.
module lzw_code_stream_decoder_top
  import lzwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] code_value, [23:21] zero
  input  logic        s_tuser,   // [0] message_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] symbol, [23:21] zero
  output logic        m_tlast,   // run_last
  output logic        m_tuser    // [0] run_truncated
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_PRIME,
    S_OUT
  } state_t;

  state_t state;

  // dictionary state
  logic [NFC_W-1:0]  nfc;         // next free code
  logic [REF_W-1:0]  prev_code;
  logic [CODE_W-1:0] prev_head;

  // per-code work registers
  logic [REF_W-1:0]  cur;         // chain walk pointer
  logic [REF_W-1:0]  item_ref;    // defined code taken, committed after the walk
  logic [CODE_W-1:0] head_cap;
  logic              first_fetch;
  logic              upd_pend;
  logic              add_pend;
  logic              has_extra;
  logic [CODE_W-1:0] extra_sym;
  logic [RING_AW-1:0] wp;
  logic [RING_AW-1:0] rp;
  logic [CNT_W-1:0]  cnt;         // symbols pushed, saturates past MAX_RUN
  logic [CNT_W-1:0]  rem;
  logic              extra_en;
  logic              cut;

  // RAM ports
  logic               dict_we;
  logic [IDX_W-1:0]   dict_waddr;
  entry_t             dict_wdata;
  logic [IDX_W-1:0]   dict_raddr;
  entry_t             dict_rdata;
  logic               ring_we;
  logic [CODE_W-1:0]  ring_wdata;
  logic [RING_AW-1:0] ring_raddr;
  logic [CODE_W-1:0]  ring_rdata;

  logic              accept;
  logic              start;
  logic [CODE_W-1:0] code;
  logic              code_lit;
  logic              code_def;
  logic              room;
  logic              cur_lit;
  logic              next_lit;
  logic [RING_AW-1:0] wp_inc;
  logic [RING_AW-1:0] rp_dec;
  logic [CNT_W-1:0]  cnt_inc;
  logic              load_ok;
  logic              ld_ring;
  logic              ld_extra;
  logic              ld_last;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign start    = s_tuser;
  assign code     = s_tdata[CODE_W-1:0];
  assign code_lit = code < CODE_W'(FIRST_FREE);
  assign code_def = !code_lit && (code < CODE_W'(nfc)) && (32'(code) < DICT_ENTRIES);
  assign room     = (nfc >= NFC_W'(FIRST_FREE)) && (32'(nfc) < DICT_ENTRIES);

  assign cur_lit  = is_literal(cur);
  assign next_lit = is_literal(dict_rdata.prefix);

  assign wp_inc  = (wp == RING_AW'(MAX_RUN - 1)) ? '0 : wp + 1'b1;
  assign rp_dec  = (rp == '0) ? RING_AW'(MAX_RUN - 1) : rp - 1'b1;
  assign cnt_inc = (cnt > CNT_W'(MAX_RUN)) ? cnt : cnt + 1'b1;

  // output loading: ring symbols first, then the appended symbol if any
  assign load_ok  = !m_tvalid || m_tready;
  assign ld_ring  = (state == S_OUT) && load_ok && (rem != '0);
  assign ld_extra = (state == S_OUT) && load_ok && (rem == '0) && extra_en;
  assign ld_last  = ld_ring ? ((rem == CNT_W'(1)) && !extra_en) : ld_extra;

  // dictionary write: literals and unknown codes add at once, defined codes
  // add after the walk has fetched their head symbol
  always_comb begin
    dict_we    = 1'b0;
    dict_waddr = nfc[IDX_W-1:0];
    dict_wdata = '{prefix: prev_code, tail: prev_head, head: prev_head};
    if (accept && !start && room && code_lit) begin
      dict_we         = 1'b1;
      dict_wdata.tail = sym_mask(code);
    end else if (accept && !start && room && !code_def) begin
      dict_we = 1'b1;
    end else if (state == S_PRIME && upd_pend && add_pend) begin
      dict_we         = 1'b1;
      dict_wdata.tail = head_cap;
    end
  end

  // chain walk reads one entry per cycle: the next address comes straight
  // from the prefix just read
  assign dict_raddr = (state == S_FETCH) ? dict_rdata.prefix[IDX_W-1:0] : cur[IDX_W-1:0];

  assign ring_we    = (state == S_FETCH) || ((state == S_WALK) && cur_lit);
  assign ring_wdata = (state == S_FETCH) ? dict_rdata.tail : sym_mask(cur[CODE_W-1:0]);
  assign ring_raddr = ld_ring ? rp_dec : rp;

  lzwd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DICT_ENTRIES)
  ) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  lzwd_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_RUN)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      nfc         <= '0;
      prev_code   <= '0;
      prev_head   <= '0;
      first_fetch <= 1'b0;
      upd_pend    <= 1'b0;
      add_pend    <= 1'b0;
      has_extra   <= 1'b0;
      extra_en    <= 1'b0;
      cnt         <= '0;
      rem         <= '0;
      wp          <= '0;
      rp          <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (ld_ring || ld_extra) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt         <= '0;
            has_extra   <= !start && !code_lit && !code_def;
            upd_pend    <= !start && code_def;
            add_pend    <= room;
            first_fetch <= !start && code_def;
            extra_sym   <= prev_head;
            state       <= S_WALK;
            if (start) begin
              nfc       <= NFC_W'(FIRST_FREE);
              prev_code <= {1'b1, code};
              prev_head <= sym_mask(code);
              cur       <= {1'b1, code};
            end else if (code_lit) begin
              cur       <= {1'b1, code};
              prev_code <= {1'b1, code};
              prev_head <= sym_mask(code);
              if (room) begin
                nfc <= nfc + 1'b1;
              end
            end else if (code_def) begin
              cur      <= REF_W'(code);
              item_ref <= REF_W'(code);
            end else begin
              // unknown code: previous string plus its own head symbol
              cur <= prev_code;
              if (room) begin
                prev_code <= REF_W'(nfc);
                nfc       <= nfc + 1'b1;
              end
            end
          end
        end

        S_WALK: begin
          if (cur_lit) begin
            rp    <= wp;
            wp    <= wp_inc;
            cnt   <= cnt_inc;
            state <= S_PRIME;
          end else begin
            state <= S_FETCH;
          end
        end

        S_FETCH: begin
          wp  <= wp_inc;
          cnt <= cnt_inc;
          cur <= dict_rdata.prefix;
          if (first_fetch) begin
            head_cap    <= dict_rdata.head;
            first_fetch <= 1'b0;
          end
          if (next_lit) begin
            state <= S_WALK;
          end
        end

        S_PRIME: begin
          rem      <= (cnt > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : cnt;
          extra_en <= has_extra && (cnt < CNT_W'(MAX_RUN));
          cut      <= (cnt > CNT_W'(MAX_RUN)) || (has_extra && (cnt == CNT_W'(MAX_RUN)));
          if (upd_pend) begin
            prev_code <= item_ref;
            prev_head <= head_cap;
            if (add_pend) begin
              nfc <= nfc + 1'b1;
            end
          end
          state <= S_OUT;
        end

        S_OUT: begin
          if (ld_ring) begin
            m_tdata  <= {3'b000, ring_rdata};
            m_tlast  <= ld_last;
            m_tuser  <= cut;
            rem      <= rem - 1'b1;
            rp       <= rp_dec;
          end else if (ld_extra) begin
            m_tdata  <= {3'b000, extra_sym};
            m_tlast  <= 1'b1;
            m_tuser  <= cut;
            extra_en <= 1'b0;
          end
          if (ld_last) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the walk always pushes the root literal before output setup
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRIME) |-> (cnt != '0))
    else $error("output setup with no symbols pushed");

  // the fill counter never passes the dictionary size
  a_nfc_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nfc) <= DICT_ENTRIES)
    else $error("next free code past dictionary end");

  // a last symbol returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    ld_last |=> (state == S_IDLE) && m_tvalid && m_tlast)
    else $error("last symbol did not end the code");

  // every code ends with something to emit
  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> ((rem != '0) || extra_en))
    else $error("output state with nothing left to send");

  // dictionary writes only land on free entries inside the table
  a_dict_write: assert property (@(posedge clk) disable iff (rst)
    dict_we |-> room)
    else $error("dictionary write without room");

endmodule
